@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the supervisor RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CCPS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CCPS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/ccps_pkg.sv @@
// ----------------------------------------------------------------------------
// ccps_pkg
// Types, codes and constants of the charge configuration phase supervisor.
// ----------------------------------------------------------------------------
package ccps_pkg;

	localparam int TICK_BITS_DEF = 32;
	localparam int NOW_W         = 32;
	localparam int VOLT_W        = 16;
	localparam int MS_W          = 16;
	localparam int FAULT_W       = 7;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;
	localparam int IN_TDATA_W    = 80;
	localparam int OUT_TDATA_W   = 16;

	// Register reset values
	localparam logic [VOLT_W-1:0] MODULE_MIN_VOLT_RST    = 16'd2000;
	localparam logic [VOLT_W-1:0] MODULE_MAX_VOLT_RST    = 16'd7500;
	localparam logic              PROTOCOL_2011_RST      = 1'b0;
	localparam logic [MS_W-1:0]   RECOG_PERIOD_MS_RST    = 16'd250;
	localparam logic [MS_W-1:0]   PARAM_TIMEOUT_MS_RST   = 16'd5000;
	localparam logic [MS_W-1:0]   REREQUEST_AFTER_MS_RST = 16'd2000;
	localparam logic [MS_W-1:0]   CC_DEBOUNCE_MS_RST     = 16'd200;

	// Code sent in the recognition frame; framing lives outside this block.
	localparam logic [7:0] RECOG_CODE = 8'hAA;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODULE_MIN_VOLT    = 3'd0,
		CFG_MODULE_MAX_VOLT    = 3'd1,
		CFG_PROTOCOL_2011      = 3'd2,
		CFG_RECOG_PERIOD_MS    = 3'd3,
		CFG_PARAM_TIMEOUT_MS   = 3'd4,
		CFG_REREQUEST_AFTER_MS = 3'd5,
		CFG_CC_DEBOUNCE_MS     = 3'd6
	} cfg_idx_t;

	typedef enum logic {
		OP_ENTER = 1'b0,
		OP_POLL  = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		PH_STAY         = 3'd0,
		PH_COMM_BREAK   = 3'd1,
		PH_CHARGE_STOP  = 3'd2,
		PH_WAIT_BATTERY = 3'd3,
		PH_CHARGE_BREAK = 3'd4
	} phase_t;

	typedef enum logic [3:0] {
		RS_NONE          = 4'd0,
		RS_START_OVER_BAT = 4'd1,
		RS_START_OVER_MOD = 4'd2,
		RS_MODMIN_OVER_BAT = 4'd3,
		RS_CANCEL        = 4'd4,
		RS_CC_OPEN       = 4'd5,
		RS_EMERGENCY     = 4'd6,
		RS_DOOR          = 4'd7,
		RS_CONTACTOR     = 4'd8,
		RS_INPUT_VOLT    = 4'd9,
		RS_NO_MODULE     = 4'd10,
		RS_METER         = 4'd11
	} reason_t;

	typedef struct packed {
		logic [VOLT_W-1:0] module_min_volt;
		logic [VOLT_W-1:0] module_max_volt;
		logic              protocol_2011;
		logic [MS_W-1:0]   recog_period_ms;
		logic [MS_W-1:0]   param_timeout_ms;
		logic [MS_W-1:0]   rerequest_after_ms;
		logic [MS_W-1:0]   cc_debounce_ms;
	} cfg_t;

	// Declared top field first so that now_ms lands in the lowest bits of tdata.
	typedef struct packed {
		logic               key_off_latched;
		logic [FAULT_W-1:0] fault_bits;
		logic               cc_connected;
		logic               charge_enable;
		logic               bem_valid;
		logic [VOLT_W-1:0]  bat_max_volt;
		logic [VOLT_W-1:0]  bat_start_volt;
		logic               bcp_valid;
		logic [NOW_W-1:0]   now_ms;
	} item_t;

	typedef struct packed {
		logic    volt_fault_flags;
		reason_t stop_reason;
		phase_t  next_phase;
		logic    param_timeout_flag;
		logic    send_rerequest;
		logic    send_recognition;
	} result_t;

	localparam int ITEM_W   = $bits(item_t);
	localparam int RESULT_W = $bits(result_t);

	// Stop reason for each pillar fault bit; both contactor bits share one code.
	function automatic reason_t fault_reason(input logic [2:0] bit_idx);
		reason_t r;
		unique case (bit_idx)
			3'd0:    r = RS_EMERGENCY;
			3'd1:    r = RS_DOOR;
			3'd2:    r = RS_CONTACTOR;
			3'd3:    r = RS_CONTACTOR;
			3'd4:    r = RS_INPUT_VOLT;
			3'd5:    r = RS_NO_MODULE;
			3'd6:    r = RS_METER;
			default: r = RS_NONE;
		endcase
		return r;
	endfunction

endpackage

@@ sv/ccps_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// ccps_cfg_regs
// Configuration register file written through the plain write port.
// ----------------------------------------------------------------------------
module ccps_cfg_regs
	import ccps_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.module_min_volt    <= MODULE_MIN_VOLT_RST;
			cfg_q.module_max_volt    <= MODULE_MAX_VOLT_RST;
			cfg_q.protocol_2011      <= PROTOCOL_2011_RST;
			cfg_q.recog_period_ms    <= RECOG_PERIOD_MS_RST;
			cfg_q.param_timeout_ms   <= PARAM_TIMEOUT_MS_RST;
			cfg_q.rerequest_after_ms <= REREQUEST_AFTER_MS_RST;
			cfg_q.cc_debounce_ms     <= CC_DEBOUNCE_MS_RST;
		end else if (cfg_we) begin
			// Indices past the list are ignored.
			unique case (cfg_index)
				CFG_MODULE_MIN_VOLT:    cfg_q.module_min_volt    <= cfg_wdata;
				CFG_MODULE_MAX_VOLT:    cfg_q.module_max_volt    <= cfg_wdata;
				CFG_PROTOCOL_2011:      cfg_q.protocol_2011      <= cfg_wdata[0];
				CFG_RECOG_PERIOD_MS:    cfg_q.recog_period_ms    <= cfg_wdata;
				CFG_PARAM_TIMEOUT_MS:   cfg_q.param_timeout_ms   <= cfg_wdata;
				CFG_REREQUEST_AFTER_MS: cfg_q.rerequest_after_ms <= cfg_wdata;
				CFG_CC_DEBOUNCE_MS:     cfg_q.cc_debounce_ms     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ sv/ccps_step.sv @@
// ----------------------------------------------------------------------------
// ccps_step
// Timer state and single-pass decision logic for one enter or poll item.
// ----------------------------------------------------------------------------
module ccps_step
	import ccps_pkg::*;
#(
	parameter int TICK_BITS = TICK_BITS_DEF
)(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  opcode_t opcode,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t res
);

	localparam int CW = TICK_BITS + 1;

	logic [TICK_BITS-1:0] last_recog_q, param_wait_q, cc_since_q;
	logic                 first_send_q, cc_active_q, flag_q;

	logic [TICK_BITS-1:0] now_t, recog_d, param_wait_eff, param_d, cc_since_eff, cc_d;
	logic                 recog_due, first_now, timeout, rereq, flag_next;
	logic                 volt_pass, cc_mid, cc_trip;
	result_t              poll_res;

	assign now_t     = item.now_ms[TICK_BITS-1:0];
	assign recog_d   = now_t - last_recog_q;
	assign recog_due = recog_d > TICK_BITS'(cfg.recog_period_ms);
	assign first_now = recog_due && !first_send_q;

	// The parameter wait restarts at the first recognition frame.
	assign param_wait_eff = first_now ? now_t : param_wait_q;
	assign param_d        = now_t - param_wait_eff;
	assign timeout        = param_d > TICK_BITS'(cfg.param_timeout_ms);
	assign rereq          = !timeout && cfg.protocol_2011 &&
		(param_d > TICK_BITS'(cfg.rerequest_after_ms));
	assign flag_next      = timeout | (rereq & flag_q);

	assign volt_pass = !(item.bat_start_volt > item.bat_max_volt) &&
		!(item.bat_start_volt > cfg.module_max_volt) &&
		!(cfg.module_min_volt > item.bat_max_volt);

	// CC open must last longer than twice the debounce setting.
	assign cc_mid       = !item.cc_connected;
	assign cc_since_eff = (cc_mid && !cc_active_q) ? now_t : cc_since_q;
	assign cc_d         = now_t - cc_since_eff;
	assign cc_trip      = cc_mid && (CW'(cc_d) > CW'({cfg.cc_debounce_ms, 1'b0}));

	always_comb begin
		poll_res                    = '0;
		poll_res.send_recognition   = recog_due;
		poll_res.send_rerequest     = rereq;
		poll_res.param_timeout_flag = flag_next;
		poll_res.next_phase         = timeout ? PH_COMM_BREAK : PH_STAY;
		poll_res.stop_reason        = RS_NONE;
		if (item.bcp_valid) begin
			if (item.bat_start_volt > item.bat_max_volt) begin
				poll_res.stop_reason      = RS_START_OVER_BAT;
				poll_res.next_phase       = PH_CHARGE_STOP;
				poll_res.volt_fault_flags = 1'b1;
			end else if (item.bat_start_volt > cfg.module_max_volt) begin
				poll_res.stop_reason      = RS_START_OVER_MOD;
				poll_res.next_phase       = PH_CHARGE_STOP;
				poll_res.volt_fault_flags = 1'b1;
			end else if (cfg.module_min_volt > item.bat_max_volt) begin
				poll_res.stop_reason      = RS_MODMIN_OVER_BAT;
				poll_res.next_phase       = PH_CHARGE_STOP;
				poll_res.volt_fault_flags = 1'b1;
			end else begin
				poll_res.next_phase = PH_WAIT_BATTERY;
			end
		end
		if (item.bem_valid) begin
			poll_res.next_phase = PH_COMM_BREAK;
		end
		if (!item.charge_enable) begin
			// A latched key-off keeps its reason unless a voltage check fired.
			if (!item.key_off_latched || (poll_res.stop_reason != RS_NONE)) begin
				poll_res.stop_reason = RS_CANCEL;
			end
			poll_res.next_phase = PH_CHARGE_STOP;
		end
		if (cc_trip) begin
			poll_res.stop_reason = RS_CC_OPEN;
			poll_res.next_phase  = PH_CHARGE_BREAK;
		end
		// Higher fault bits take precedence over lower ones.
		for (int b = 0; b < FAULT_W; b++) begin
			if (item.fault_bits[b]) begin
				poll_res.stop_reason = fault_reason(3'(b));
				poll_res.next_phase  = PH_CHARGE_BREAK;
			end
		end
	end

	always_comb begin
		case (opcode)
			OP_POLL: res = poll_res;
			default: begin
				res                    = '0;
				res.param_timeout_flag = flag_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_recog_q <= '0;
			param_wait_q <= '0;
			cc_since_q   <= '0;
			first_send_q <= 1'b0;
			cc_active_q  <= 1'b0;
			flag_q       <= 1'b0;
		end else if (fire) begin
			case (opcode)
				OP_POLL: begin
					if (item.bcp_valid && volt_pass) begin
						last_recog_q <= '0;
					end else if (recog_due) begin
						last_recog_q <= now_t;
					end
					param_wait_q <= param_wait_eff;
					first_send_q <= first_send_q | recog_due;
					flag_q       <= flag_next;
					cc_since_q   <= cc_since_eff;
					cc_active_q  <= cc_mid && !cc_trip;
				end
				default: begin
					param_wait_q <= now_t;
					first_send_q <= 1'b0;
					cc_since_q   <= '0;
					cc_active_q  <= 1'b0;
				end
			endcase
		end
	end

endmodule

@@ sv/charge_config_phase_supervisor.sv @@
// ----------------------------------------------------------------------------
// charge_config_phase_supervisor
// Configuration phase supervisor of a DC charger: recognition pacing,
// parameter timeout and re-request, voltage checks and stop priority.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat contents
//  -------   ---------  -----------------------------------------------------
//  s_axis    in         tuser = opcode; tdata = item fields, now_ms lowest
//  m_axis    out        tdata = result flags, phase and stop reason
//  cfg       in         one register write per cycle with cfg_we high
//
//  An accepted item is held in the input register, then passes through the decision
//  logic into the result register, from which the result is offered. A new item may
//  be accepted every cycle while the output does not stall, and the timer state is
//  updated as an item leaves the input register.
//  An output stall holds the result register; the input register takes one more
//  beat, then the input side is held back. arst_n clears valid flags and state.
//
module charge_config_phase_supervisor
	import ccps_pkg::*;
#(
	parameter int TICK_BITS = TICK_BITS_DEF
)(
	input  logic                   clk,
	input  logic                   arst_n,
	// Input stream
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// [31:0] now_ms, [32] bcp_valid, [48:33] bat_start_volt,
	// [64:49] bat_max_volt, [65] bem_valid, [66] charge_enable,
	// [67] cc_connected, [74:68] fault_bits, [75] key_off_latched, [79:76] zero
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// [0] opcode
	input  logic                   s_axis_tuser,
	// Result stream
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [0] send_recognition, [1] send_rerequest, [2] param_timeout_flag,
	// [5:3] next_phase, [9:6] stop_reason, [10] volt_fault_flags, [15:11] zero
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// Configuration write port
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	cfg_t    cfg;
	item_t   item_s1;
	opcode_t op_s1;
	logic    valid_s1;
	result_t step_res;
	result_t res_q;
	logic    out_valid_q;
	logic    advance;

	ccps_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// The held item moves on whenever the result register is free or draining.
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Payload registers need no reset.
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= item_t'(s_axis_tdata[ITEM_W-1:0]);
			op_s1   <= opcode_t'(s_axis_tuser);
		end
	end

	ccps_step #(
		.TICK_BITS (TICK_BITS)
	) u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.opcode (op_s1),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= step_res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_TDATA_W - RESULT_W)'(0), res_q};

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
`include "assert_macros.svh"

	`CCPS_ASSERT_NXT(a_advance_fills_out, clk, arst_n, advance, out_valid_q, "result beat lost after advance")
	`CCPS_ASSERT_IMP(a_ready_only_blocked_when_full, clk, arst_n, !s_axis_tready, valid_s1, "input held back with empty input register")
	`CCPS_ASSERT_IMP(a_vflag_has_reason, clk, arst_n, out_valid_q && res_q.volt_fault_flags, res_q.stop_reason != RS_NONE, "voltage fault without stop reason")
	`CCPS_ASSERT_IMP(a_cc_open_breaks, clk, arst_n, out_valid_q && (res_q.stop_reason == RS_CC_OPEN), res_q.next_phase == PH_CHARGE_BREAK, "CC open without charge break")

endmodule
